// ===== hw/rtl/sstq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_pkg
// Shared types and codes of the sorted timer queue.
// ----------------------------------------------------------------------------
package sstq_pkg;

  localparam int ID_W  = 5;
  localparam int DL_W  = 32;
  localparam int TAG_W = 32;
  localparam int Q_W   = 2;

  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_INIT  = 3'd2;
  localparam logic [2:0] CMD_SET   = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  typedef enum logic [2:0] {
    K_ALLOCATED = 3'd0,
    K_NONE_FREE = 3'd1,
    K_ACK       = 3'd2,
    K_ERROR     = 3'd3,
    K_EXPIRED   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  timer_id;
    logic [DL_W-1:0]  delay;
    logic [TAG_W-1:0] tag_value;
    logic [Q_W-1:0]   dest_queue;
  } cmd_word_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  result_timer;
    logic [TAG_W-1:0] result_tag;
    logic [Q_W-1:0]   result_queue;
    logic             last;
  } rsp_word_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] new_id;
    logic [DL_W-1:0] new_dl;
    logic [DL_W-1:0] now;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_CHECK
  } state_t;

endpackage

// ===== hw/rtl/sstq_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_cmd_if
// Command channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface sstq_cmd_if;
  logic                 valid;
  logic                 ready;
  sstq_pkg::cmd_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sstq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_rsp_if
// Response channel: valid, ready and one response word.
// ----------------------------------------------------------------------------
interface sstq_rsp_if;
  logic                 valid;
  logic                 ready;
  sstq_pkg::rsp_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sstq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_cell
// One slot of the sorted list: holds one running timer and its deadline.
// ----------------------------------------------------------------------------
module sstq_cell (
  input  logic                clk,
  input  logic                rst,
  input  sstq_pkg::cell_ctrl_t ctrl,
  input  sstq_pkg::entry_t    prev_e,
  input  logic                prev_goes,
  input  sstq_pkg::entry_t    next_e,
  output sstq_pkg::entry_t    e,
  output logic                goes,
  output logic                expd
);
  import sstq_pkg::*;

  logic                valid;
  logic [ID_W-1:0]     id;
  logic [DL_W-1:0]     dl;

  assign e    = '{valid: valid, id: id, dl: dl};
  // slot at or behind the insert point
  assign goes = !valid || (dl >= ctrl.new_dl);
  assign expd = valid && (dl <= ctrl.now);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_INSERT: begin
          if (prev_goes) begin
            valid <= prev_e.valid;
          end else if (goes) begin
            valid <= 1'b1;
          end
        end
        CELL_POP: valid <= next_e.valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (prev_goes) begin
          id <= prev_e.id;
          dl <= prev_e.dl;
        end else if (goes) begin
          id <= ctrl.new_id;
          dl <= ctrl.new_dl;
        end
      end
      CELL_POP: begin
        id <= next_e.id;
        dl <= next_e.dl;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/sstq_tag_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstq_tag_mem
// Tag and destination queue store, one write port, registered read.
// ----------------------------------------------------------------------------
module sstq_tag_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/sorted_software_timer_queue_core.sv =====
`timescale 1ns / 1ps
// Responses: allocate, free, init and error answer in the cycle after the word is
//   taken; set answers likewise and, when accepted, holds off the next word for the list insert.
// A tick enters the check state and pops expired timers off the list head, one
//   list pop per cycle while the output slot is free, until the head has not expired.
// Throughput: one word per cycle for allocate, free, init and error while each
//   response is taken; a set or a tick holds off the next word until it is done.
// Reset (synchronous, rst high) empties the list, zeroes the tick counter and
//   marks every timer unused; tags stay undefined until init.
// ----------------------------------------------------------------------------
// sorted_software_timer_queue_core
// Pool of one-shot timers with a tick counter and a deadline-ordered list
// held in a row of cells that shift right on insert and left on expiry.
// ----------------------------------------------------------------------------
module sorted_software_timer_queue_core #(
  parameter int NUM_TIMERS = 32
) (
  input  logic       clk,
  input  logic       rst,
  sstq_cmd_if.sink   cmd,
  sstq_rsp_if.source rsp
);
  import sstq_pkg::*;

  localparam int POOL  = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
  localparam int IDX_W = $clog2(POOL);

  state_t state, state_next;

  logic [DL_W-1:0]  tick_count;
  logic [POOL-1:0]  used;      // flags nonzero: allocated or running
  logic [POOL-1:0]  in_list;   // timer sits in the running list
  logic [ID_W-1:0]  new_id;
  logic [DL_W-1:0]  new_dl;

  logic             out_valid;
  kind_t            out_kind;
  logic [ID_W-1:0]  out_id;
  logic             out_last;
  logic             out_exp;

  cell_ctrl_t       ctrl;
  entry_t           ent  [POOL];
  logic [POOL-1:0]  goes;
  logic [POOL-1:0]  expd;
  logic [POOL-1:0]  cell_valid;

  logic [TAG_W+Q_W-1:0] tag_q;

  logic             in_fire;
  logic             out_free;
  logic             id_ok;
  logic [IDX_W-1:0] idx;
  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic             pop;

  // ---------------------------------------------------------------- handshake
  assign out_free = !out_valid || rsp.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign in_fire = cmd.valid && cmd.ready;

  assign id_ok = {1'b0, cmd.data.timer_id} < (ID_W + 1)'(POOL);
  assign idx   = cmd.data.timer_id[IDX_W-1:0];

  // lowest unused timer
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = POOL - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // pop the head while it has expired and the output slot is free
  assign pop = (state == ST_CHECK) && expd[0] && out_free;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && cmd.data.command == CMD_TICK) begin
          state_next = ST_CHECK;
        end else if (in_fire && cmd.data.command == CMD_SET && id_ok && !in_list[idx]) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_CHECK: begin
        if (!expd[0] || (pop && !expd[1])) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- cell control
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.new_id = new_id;
    ctrl.new_dl = new_dl;
    ctrl.now    = tick_count;
    unique case (state)
      ST_INSERT: ctrl.op = CELL_INSERT;
      ST_CHECK:  ctrl.op = pop ? CELL_POP : CELL_HOLD;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  // ---------------------------------------------------------------- cell row
  for (genvar g = 0; g < POOL; g++) begin : g_cell
    entry_t pe, ne;
    logic   pg;
    if (g == 0) begin : g_first
      assign pe = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pe = ent[g-1];
      assign pg = goes[g-1];
    end
    if (g == POOL - 1) begin : g_lastc
      assign ne = '0;
    end else begin : g_midn
      assign ne = ent[g+1];
    end
    sstq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_e    (pe),
      .prev_goes (pg),
      .next_e    (ne),
      .e         (ent[g]),
      .goes      (goes[g]),
      .expd      (expd[g])
    );
    assign cell_valid[g] = ent[g].valid;
  end

  // ---------------------------------------------------------------- tag store
  sstq_tag_mem #(
    .DEPTH (POOL),
    .WIDTH (TAG_W + Q_W)
  ) u_tag_mem (
    .clk   (clk),
    .we    (in_fire && cmd.data.command == CMD_INIT && id_ok),
    .waddr (idx),
    .wdata ({cmd.data.tag_value, cmd.data.dest_queue}),
    .re    (pop),
    .raddr (ent[0].id[IDX_W-1:0]),
    .rdata (tag_q)
  );

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      used       <= '0;
      in_list    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        case (cmd.data.command)
          CMD_ALLOC: begin
            out_valid <= 1'b1;
            if (found) begin
              used[free_idx] <= 1'b1;
            end
          end
          CMD_FREE: begin
            out_valid <= 1'b1;
            if (id_ok) begin
              used[idx] <= 1'b0;
            end
          end
          CMD_SET: begin
            out_valid <= 1'b1;
            if (id_ok && !in_list[idx]) begin
              used[idx]    <= 1'b1;
              in_list[idx] <= 1'b1;
            end
          end
          CMD_TICK: tick_count <= tick_count + 1'b1;
          default: out_valid <= 1'b1;
        endcase
      end
      if (pop) begin
        out_valid                  <= 1'b1;
        used[ent[0].id[IDX_W-1:0]]    <= 1'b1;
        in_list[ent[0].id[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_exp  <= 1'b0;
      out_last <= 1'b1;
      out_id   <= '0;
      out_kind <= K_ERROR;
      case (cmd.data.command)
        CMD_ALLOC: begin
          out_kind <= found ? K_ALLOCATED : K_NONE_FREE;
          out_id   <= found ? ID_W'(free_idx) : '0;
        end
        CMD_FREE, CMD_INIT: begin
          if (id_ok) begin
            out_kind <= K_ACK;
            out_id   <= cmd.data.timer_id;
          end
        end
        CMD_SET: begin
          if (id_ok && !in_list[idx]) begin
            out_kind <= K_ACK;
            out_id   <= cmd.data.timer_id;
          end
        end
        default: ;
      endcase
      // deadline wraps at 32 bits
      new_dl <= tick_count + cmd.data.delay;
      new_id <= cmd.data.timer_id;
    end
    if (pop) begin
      out_exp  <= 1'b1;
      out_kind <= K_EXPIRED;
      out_id   <= ent[0].id;
      out_last <= !expd[1];
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.data.kind         = out_kind;
  assign rsp.data.result_timer = out_id;
  assign rsp.data.result_tag   = out_exp ? tag_q[TAG_W+Q_W-1:Q_W] : '0;
  assign rsp.data.result_queue = out_exp ? tag_q[Q_W-1:0] : '0;
  assign rsp.data.last         = out_last;

  // ---------------------------------------------------------------- checks
  // the membership mark is set when the set word is taken and leads the cell row through the insert state
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (state != ST_INSERT) |-> $countones(in_list) == $countones(cell_valid))
    else $error("list membership and cell occupancy disagree");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> cell_valid[0])
    else $error("gap at the head of the cell row");

  a_head_member: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] |-> in_list[ent[0].id[IDX_W-1:0]])
    else $error("head timer not marked as listed");

  a_pop_sets_valid: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && out_kind == K_EXPIRED)
    else $error("expiry popped without a response");
endmodule
